// ===== rtl/core/qsp_pkg.sv =====
`timescale 1ns / 1ps

package qsp_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV_WT,
        ST_OUTER,
        ST_R_RD,
        ST_R_CHK,
        ST_L_RD,
        ST_L_CHK,
        ST_SWAP_L,
        ST_SWAP_R,
        ST_FIN_0,
        ST_FIN_R,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        logic load;
        logic last;
    } t_emit;

endpackage

// ===== rtl/core/qsp_in_if.sv =====
`timescale 1ns / 1ps

interface qsp_in_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== rtl/core/qsp_out_if.sv =====
`timescale 1ns / 1ps

interface qsp_out_if #(
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 6
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value_res;
    logic [POS_W-1:0]             pivot_position;
    logic                         last_res;

    modport source (output valid, output value_res, output pivot_position, output last_res,
                    input ready);
    modport sink   (input valid, input value_res, input pivot_position, input last_res,
                    output ready);
endinterface

// ===== rtl/core/qsp_ram.sv =====
`timescale 1ns / 1ps

module qsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/qsp_ctrl.sv =====
`timescale 1ns / 1ps

module qsp_ctrl
    import qsp_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int DATA_WIDTH   = 32,
    parameter int POS_W        = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic                         i_last,
    output logic                         o_ready,
    output logic                         o_we,
    output logic [POS_W-1:0]             o_waddr,
    output logic [DATA_WIDTH-1:0]        o_wdata,
    output logic [POS_W-1:0]             o_raddr,
    input  logic [DATA_WIDTH-1:0]        i_rdata,
    input  logic                         i_out_free,
    output t_emit                        o_emit,
    output logic [POS_W-1:0]             o_pos
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0]    FULL_CNT = CW'(MAX_ELEMENTS);
    localparam logic [POS_W-1:0] TOP_IDX  = POS_W'(MAX_ELEMENTS - 1);

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [POS_W-1:0]             r_nm1, n_nm1;
    logic [POS_W-1:0]             r_lp, n_lp;
    logic [POS_W-1:0]             r_rp, n_rp;
    logic [POS_W-1:0]             r_k, n_k;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic signed [DATA_WIDTH-1:0] r_pivot, n_pivot;
    logic [DATA_WIDTH-1:0]        r_rval, n_rval;
    logic [DATA_WIDTH-1:0]        r_lval, n_lval;
    logic                         w_full;
    logic                         w_greater;
    logic [POS_W-1:0]             w_rp_dec;
    logic [POS_W-1:0]             w_lp_inc;

    assign w_full    = (r_cnt == FULL_CNT);
    assign w_greater = ($signed(i_rdata) > r_pivot);
    assign w_rp_dec  = r_rp - POS_W'(1);
    assign w_lp_inc  = r_lp + POS_W'(1);
    assign o_pos     = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_nm1   <= '0;
            r_lp    <= '0;
            r_rp    <= '0;
            r_k     <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_nm1   <= n_nm1;
            r_lp    <= n_lp;
            r_rp    <= n_rp;
            r_k     <= n_k;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pivot <= n_pivot;
        r_rval  <= n_rval;
        r_lval  <= n_lval;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_nm1   = r_nm1;
        n_lp    = r_lp;
        n_rp    = r_rp;
        n_k     = r_k;
        n_pos   = r_pos;
        n_pivot = r_pivot;
        n_rval  = r_rval;
        n_lval  = r_lval;
        o_ready = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_cnt[POS_W-1:0];
        o_wdata = i_value;
        o_raddr = '0;
        o_emit  = '0;
        case (r_state)
            ST_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (!w_full) begin
                        o_we  = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end
                    if (i_last) begin
                        n_nm1 = w_full ? TOP_IDX : r_cnt[POS_W-1:0];
                        n_cnt = '0;
                        n_lp  = '0;
                        n_rp  = n_nm1;
                        n_k   = '0;
                        n_pos = '0;
                        if (n_nm1 == '0) begin
                            n_state = ST_EMIT_RD;
                        end else begin
                            n_state = ST_PIV_RD;
                        end
                    end
                end
            end
            ST_PIV_RD: begin
                o_raddr = '0;
                n_state = ST_PIV_WT;
            end
            ST_PIV_WT: begin
                n_pivot = $signed(i_rdata);
                n_state = ST_OUTER;
            end
            ST_OUTER: begin
                n_pos = r_rp;
                n_k   = '0;
                if (r_lp < r_rp) begin
                    n_state = ST_R_RD;
                end else if (r_rp != '0) begin
                    n_state = ST_FIN_0;
                end else begin
                    n_state = ST_EMIT_RD;
                end
            end
            ST_R_RD: begin
                if (r_rp != '0) begin
                    o_raddr = r_rp;
                    n_state = ST_R_CHK;
                end else begin
                    n_state = ST_L_RD;
                end
            end
            ST_R_CHK: begin
                if (w_greater) begin
                    n_rp = w_rp_dec;
                    if (w_rp_dec != '0) begin
                        o_raddr = w_rp_dec;
                    end else begin
                        n_state = ST_L_RD;
                    end
                end else begin
                    n_rval  = i_rdata;
                    n_state = ST_L_RD;
                end
            end
            ST_L_RD: begin
                if (r_lp < r_rp) begin
                    o_raddr = r_lp;
                    n_state = ST_L_CHK;
                end else begin
                    n_state = ST_SWAP_L;
                end
            end
            ST_L_CHK: begin
                if (!w_greater) begin
                    n_lp = w_lp_inc;
                    if (w_lp_inc < r_rp) begin
                        o_raddr = w_lp_inc;
                    end else begin
                        n_state = ST_SWAP_L;
                    end
                end else begin
                    n_lval  = i_rdata;
                    n_state = ST_SWAP_L;
                end
            end
            ST_SWAP_L: begin
                if (r_lp < r_rp) begin
                    o_we    = 1'b1;
                    o_waddr = r_lp;
                    o_wdata = r_rval;
                    n_state = ST_SWAP_R;
                end else begin
                    n_state = ST_OUTER;
                end
            end
            ST_SWAP_R: begin
                o_we    = 1'b1;
                o_waddr = r_rp;
                o_wdata = r_lval;
                n_state = ST_OUTER;
            end
            ST_FIN_0: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = r_rval;
                n_state = ST_FIN_R;
            end
            ST_FIN_R: begin
                o_we    = 1'b1;
                o_waddr = r_rp;
                o_wdata = r_pivot;
                n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                if (i_out_free) begin
                    o_raddr = r_k;
                    n_state = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                o_emit.load = 1'b1;
                o_emit.last = (r_k == r_nm1);
                n_k         = r_k + POS_W'(1);
                if (r_k == r_nm1) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/core/qsp_out_reg.sv =====
`timescale 1ns / 1ps

module qsp_out_reg
    import qsp_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_emit                 i_emit,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic [POS_W-1:0]      i_pos,
    output logic                  o_free,
    qsp_out_if.source             o_res
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic [POS_W-1:0]      r_pos;
    logic                  r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.load) begin
            r_data <= i_data;
            r_pos  <= i_pos;
            r_last <= i_emit.last;
        end
    end

    assign o_free               = !r_valid || o_res.ready;
    assign o_res.valid          = r_valid;
    assign o_res.value_res      = $signed(r_data);
    assign o_res.pivot_position = r_pos;
    assign o_res.last_res       = r_last;

endmodule

// ===== rtl/core/quicksort_partition.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload                                Transaction
// i_item    in         value, last                            valid && ready
// o_res     out        value_res, pivot_position, last_res    valid && ready
//
// Loading takes one cycle per word; ready is high only while loading.
// The final word starts the partition on the word memory: the pivot is read from slot 0, then
// each scan pass checks words from the right and from the left and swaps the pair it finds.
// Emission reads each word from memory, then loads it into the output register; it waits under stall.
// Synchronous active-low reset returns to loading with an empty block; no clearing pass.
// A stalled result holds in the output register while the next block loads.

module quicksort_partition
    import qsp_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int DATA_WIDTH   = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qsp_in_if.sink    i_item,
    qsp_out_if.source o_res
);

    localparam int POS_W = $clog2(MAX_ELEMENTS);

    logic                  w_we;
    logic [POS_W-1:0]      w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [POS_W-1:0]      w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic                  w_out_free;
    t_emit                 w_emit;
    logic [POS_W-1:0]      w_pos;

    qsp_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    qsp_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .DATA_WIDTH   (DATA_WIDTH),
        .POS_W        (POS_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_item.valid),
        .i_value    (i_item.value),
        .i_last     (i_item.last),
        .o_ready    (i_item.ready),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata),
        .i_out_free (w_out_free),
        .o_emit     (w_emit),
        .o_pos      (w_pos)
    );

    qsp_out_reg #(
        .DATA_WIDTH (DATA_WIDTH),
        .POS_W      (POS_W)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_data  (w_rdata),
        .i_pos   (w_pos),
        .o_free  (w_out_free),
        .o_res   (o_res)
    );

endmodule

// ===== tb/sv/tb_quicksort_partition.sv =====
`timescale 1ns / 1ps

module tb_quicksort_partition;

    localparam int MAX_ELEMENTS  = 64;
    localparam int DATA_WIDTH    = 32;
    localparam int POS_W         = 6;
    localparam int RANDOM_ITEMS  = 320;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_NS      = 3_000_000;
    localparam int DIR_ROWS      = 21;

    localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] word;
        logic                         last;
        logic                         typed;
    } dir_row_t;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] word;
        logic [POS_W-1:0]             pos;
        logic                         last;
    } part_word_t;

    logic i_clk;
    logic i_rst_n;

    qsp_in_if  #(.DATA_WIDTH(DATA_WIDTH))                  item_if ();
    qsp_out_if #(.DATA_WIDTH(DATA_WIDTH), .POS_W(POS_W))   res_if ();

    quicksort_partition #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_if),
        .o_res  (res_if)
    );

    // Single-word blocks carry their result in the row: the word itself at position 0.
    dir_row_t dir_table [0:DIR_ROWS-1] = '{
        '{32'sd0,          1'b1, 1'b1},
        '{WORD_MAX,        1'b1, 1'b1},
        '{WORD_MIN,        1'b1, 1'b1},
        '{WORD_MIN,        1'b0, 1'b0},
        '{WORD_MAX,        1'b1, 1'b0},
        '{WORD_MAX,        1'b0, 1'b0},
        '{WORD_MIN,        1'b1, 1'b0},
        '{32'sd5,          1'b0, 1'b0},
        '{32'sd5,          1'b0, 1'b0},
        '{32'sd5,          1'b0, 1'b0},
        '{32'sd5,          1'b1, 1'b0},
        '{32'sd3,          1'b0, 1'b0},
        '{-32'sd1,         1'b0, 1'b0},
        '{32'sd7,          1'b0, 1'b0},
        '{32'sd3,          1'b0, 1'b0},
        '{-32'sd8,         1'b1, 1'b0},
        '{-32'sd1,         1'b0, 1'b0},
        '{32'sh5555_5555,  1'b0, 1'b0},
        '{32'shAAAA_AAAA,  1'b0, 1'b0},
        '{32'sd1,          1'b1, 1'b0},
        '{-32'sd1,         1'b1, 1'b1}
    };

    logic signed [DATA_WIDTH-1:0] blk_words [0:MAX_ELEMENTS-1];
    int                           blk_count;
    part_word_t                   pending_words [$];
    int                           mismatch_count;
    bit                           src_idle;
    bit                           sink_idle;
    bit                           hold_req;
    bit                           drive_typed;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Rearrange the stored block around its first word; return the pivot's final slot.
    function automatic int partition_block();
        int                           lo;
        int                           hi;
        logic signed [DATA_WIDTH-1:0] pivot;
        logic signed [DATA_WIDTH-1:0] tmp;
        hi = 0;
        if (blk_count > 1) begin
            lo    = 0;
            hi    = blk_count - 1;
            pivot = blk_words[0];
            while (lo < hi) begin
                while (hi > 0 && blk_words[hi] > pivot)
                    hi--;
                while (lo < hi && !(blk_words[lo] > pivot))
                    lo++;
                if (lo < hi) begin
                    tmp           = blk_words[lo];
                    blk_words[lo] = blk_words[hi];
                    blk_words[hi] = tmp;
                end
            end
            tmp           = blk_words[hi];
            blk_words[hi] = blk_words[0];
            blk_words[0]  = tmp;
        end
        return hi;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_word(
        input logic signed [DATA_WIDTH-1:0] first
    );
        logic signed [DATA_WIDTH-1:0] w;
        case ($urandom_range(0, 5))
            0, 1: w = $urandom;
            2, 3: w = $signed($urandom_range(0, 8)) - 4;
            4: begin
                case ($urandom_range(0, 3))
                    0: w = WORD_MAX;
                    1: w = WORD_MIN;
                    2: w = -1;
                    default: w = 0;
                endcase
            end
            default: w = first;
        endcase
        return w;
    endfunction

    task automatic send_word(
        input logic signed [DATA_WIDTH-1:0] w,
        input logic                         fin,
        input logic                         typed
    );
        int gap;
        gap = src_idle ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            item_if.valid = 1'b0;
        end
        @(negedge i_clk);
        item_if.valid = 1'b1;
        item_if.value = w;
        item_if.last  = fin;
        drive_typed   = typed;
        @(posedge i_clk);
        while (!item_if.ready)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : scoreboard
        part_word_t want;
        int         pos;
        int         k;
        if (i_rst_n) begin
            if (item_if.valid && item_if.ready) begin
                if (blk_count < MAX_ELEMENTS) begin
                    blk_words[blk_count] = item_if.value;
                    blk_count++;
                end
                if (item_if.last) begin
                    pos = partition_block();
                    if (drive_typed) begin
                        pending_words.push_back('{item_if.value, '0, 1'b1});
                    end else begin
                        for (k = 0; k < blk_count; k++)
                            pending_words.push_back('{blk_words[k], pos[POS_W-1:0],
                                                      k == blk_count - 1});
                    end
                    blk_count = 0;
                end
            end
            if (res_if.valid && res_if.ready) begin
                if (pending_words.size() == 0) begin
                    $error("unexpected result: value_res %0d, pivot_position %0d, last_res %0b",
                           res_if.value_res, res_if.pivot_position, res_if.last_res);
                    mismatch_count++;
                end else begin
                    want = pending_words.pop_front();
                    if (res_if.value_res !== want.word) begin
                        $error("value_res: expected %0d, actual %0d", want.word, res_if.value_res);
                        mismatch_count++;
                    end
                    if (res_if.pivot_position !== want.pos) begin
                        $error("pivot_position: expected %0d, actual %0d",
                               want.pos, res_if.pivot_position);
                        mismatch_count++;
                    end
                    if (res_if.last_res !== want.last) begin
                        $error("last_res: expected %0b, actual %0b", want.last, res_if.last_res);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : result_sink
        int gap;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = sink_idle ? $urandom_range(0, 3) : 0;
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            repeat (gap) begin
                @(negedge i_clk);
                res_if.ready = 1'b0;
            end
            @(negedge i_clk);
            res_if.ready = 1'b1;
            @(posedge i_clk);
            while (!res_if.valid)
                @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int                           sent;
        int                           blk_idx;
        int                           blk_len;
        int                           j;
        logic signed [DATA_WIDTH-1:0] first_word;
        logic signed [DATA_WIDTH-1:0] w;
        i_rst_n        = 1'b0;
        item_if.valid  = 1'b0;
        item_if.value  = '0;
        item_if.last   = 1'b0;
        blk_count      = 0;
        mismatch_count = 0;
        src_idle       = 1'b1;
        sink_idle      = 1'b1;
        hold_req       = 1'b0;
        drive_typed    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (j = 0; j < DIR_ROWS; j++)
            send_word(dir_table[j].word, dir_table[j].last, dir_table[j].typed);

        sent    = 0;
        blk_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            if (blk_idx == 2)
                blk_len = MAX_ELEMENTS;
            else if (blk_idx == 5 || blk_idx == 11)
                blk_len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 8);
            else if (blk_idx % 7 == 6)
                blk_len = $urandom_range(12, 30);
            else
                blk_len = $urandom_range(1, 10);
            // Starve the result side while the next blocks keep arriving
            if (blk_idx == 3)
                hold_req = 1'b1;
            first_word = $urandom;
            for (j = 0; j < blk_len; j++) begin
                w = (j == 0) ? first_word : pick_word(first_word);
                send_word(w, j == blk_len - 1, 1'b0);
            end
            sent += blk_len;
            blk_idx++;
        end

        @(negedge i_clk);
        item_if.valid = 1'b0;
        item_if.last  = 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
